// ===== src/pfd_pkg.sv =====
// Shared types, constants and helpers for the Playfair digraph decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pfd_pkg;

  localparam int unsigned SqSize = 5;
  localparam int unsigned CharW  = 8;
  localparam int unsigned RowW   = SqSize * CharW;
  localparam int unsigned CoordW = $clog2(SqSize);
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned ApbAddrW = 6;
  localparam int unsigned RegLsb   = 3;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [CoordW-1:0] coord_t;
  typedef logic [RowW-1:0]   row_word_t;

  // key[r][c]: row r, column c; a row packs column c at bits 8c+7:8c
  typedef logic [SqSize-1:0][SqSize-1:0][CharW-1:0] key_sq_t;

  // match[r][c] set where the key cell equals the character
  typedef logic [SqSize-1:0][SqSize-1:0] match_t;

  typedef enum logic [ApbAddrW-RegLsb-1:0] {
    RegKeyRow0 = 3'd0,
    RegKeyRow1 = 3'd1,
    RegKeyRow2 = 3'd2,
    RegKeyRow3 = 3'd3,
    RegKeyRow4 = 3'd4
  } pfd_reg_e;

  typedef struct packed {
    match_t m_a;
    match_t m_b;
  } pfd_match_t;

  typedef struct packed {
    logic   hit;
    coord_t row;
    coord_t col;
  } pfd_pos_t;

  // located or target positions of both letters
  typedef struct packed {
    logic   found;
    coord_t row_a;
    coord_t col_a;
    coord_t row_b;
    coord_t col_b;
  } pfd_coord_t;

  localparam coord_t CoordLast = coord_t'(SqSize - 1);

  function automatic coord_t dec_wrap(coord_t x);
    coord_t r;
    r = (x == '0) ? CoordLast : coord_t'(x - 1'b1);
    return r;
  endfunction

  // first match in row-major order: pick the row, then the column in it
  function automatic pfd_pos_t first_hit(match_t m);
    pfd_pos_t             p;
    logic [SqSize-1:0]    row_any;
    logic [SqSize-1:0]    row_bits;
    p = '0;
    row_bits = '0;
    for (int r = 0; r < SqSize; r++) begin
      row_any[r] = |m[r];
    end
    for (int r = SqSize - 1; r >= 0; r--) begin
      if (row_any[r]) begin
        p.row    = coord_t'(r);
        row_bits = m[r];
      end
    end
    for (int c = SqSize - 1; c >= 0; c--) begin
      if (row_bits[c]) begin
        p.col = coord_t'(c);
      end
    end
    p.hit = |row_any;
    return p;
  endfunction

endpackage

// ===== src/pfd_ifs.sv =====
// Valid/ready stream interfaces for ciphertext and plaintext words.
// Depends on pfd_pkg for the character type.
`timescale 1ns / 1ps

interface pfd_in_if;
  import pfd_pkg::*;
  logic  valid;
  logic  ready;
  char_t cipher_first;
  char_t cipher_second;
  modport source (output valid, output cipher_first, output cipher_second, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

interface pfd_out_if;
  import pfd_pkg::*;
  logic  valid;
  logic  ready;
  char_t plain_first;
  char_t plain_second;
  logic  found;
  modport source (output valid, output plain_first, output plain_second, output found,
                  input ready);
  modport sink   (input valid, input plain_first, input plain_second, input found,
                  output ready);
endinterface

// ===== src/playfair_digraph_decoder.sv =====
// Top level of the Playfair digraph decoder: key registers plus a
// four-stage decode pipeline. Depends on pfd_pkg, pfd_ifs, pfd_cfg_regs,
// pfd_locate and pfd_pick.
//
//   port       dir  handshake        payload
//   cipher_i   in   valid/ready      cipher_first, cipher_second
//   plain_o    out  valid/ready      plain_first, plain_second, found
//   APB        in   psel/penable     key_row0..4 at 8*i, 64-bit data
//
// One word per cycle sustained while plain_o is ready; each word passes the
// compare, encode, rule and cell read registers in that order.
// Each stage holds its word while the next is full, so a stall on plain_o
// backs up one stage at a time and loses nothing; empty stages keep taking
// words. Reset clears the key rows to zero and empties the pipeline.
`timescale 1ns / 1ps

module playfair_digraph_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pfd_in_if.sink                        cipher_i,
  pfd_out_if.source                     plain_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [pfd_pkg::ApbDataW-1:0]  pwdata,
  output logic [pfd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import pfd_pkg::*;

  key_sq_t    key;
  logic       loc_valid, loc_ready;
  pfd_coord_t loc;

  pfd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  pfd_locate u_locate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key),
    .cipher_i    (cipher_i),
    .loc_valid_o (loc_valid),
    .loc_ready_i (loc_ready),
    .loc_o       (loc)
  );

  pfd_pick u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key),
    .loc_valid_i (loc_valid),
    .loc_ready_o (loc_ready),
    .loc_i       (loc),
    .plain_o     (plain_o)
  );

endmodule

// ===== src/pfd_cfg_regs.sv =====
// APB-style register file holding the five key square rows.
// Depends on pfd_pkg.
`timescale 1ns / 1ps

module pfd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [pfd_pkg::ApbDataW-1:0]  pwdata,
  output logic [pfd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output pfd_pkg::key_sq_t              key_o
);
  import pfd_pkg::*;

  row_word_t key_q [SqSize];
  logic      wr_en;
  pfd_reg_e  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = pfd_reg_e'(paddr[ApbAddrW-1:RegLsb]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < SqSize; r++) key_q[r] <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegKeyRow0: key_q[0] <= pwdata[RowW-1:0];
        RegKeyRow1: key_q[1] <= pwdata[RowW-1:0];
        RegKeyRow2: key_q[2] <= pwdata[RowW-1:0];
        RegKeyRow3: key_q[3] <= pwdata[RowW-1:0];
        RegKeyRow4: key_q[4] <= pwdata[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegKeyRow0: prdata = ApbDataW'(key_q[0]);
      RegKeyRow1: prdata = ApbDataW'(key_q[1]);
      RegKeyRow2: prdata = ApbDataW'(key_q[2]);
      RegKeyRow3: prdata = ApbDataW'(key_q[3]);
      RegKeyRow4: prdata = ApbDataW'(key_q[4]);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < SqSize; r++) key_o[r] = key_q[r];
  end

endmodule

// ===== src/pfd_locate.sv =====
// Stages 1-2: compare both letters against all key cells, then encode the
// first match of each into row/column. Depends on pfd_pkg and pfd_in_if.
`timescale 1ns / 1ps

module pfd_locate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfd_pkg::key_sq_t   key_i,
  pfd_in_if.sink             cipher_i,
  output logic               loc_valid_o,
  input  logic               loc_ready_i,
  output pfd_pkg::pfd_coord_t loc_o
);
  import pfd_pkg::*;

  logic       s1_valid_q, s2_valid_q;
  logic       s1_ready, s2_ready;
  pfd_match_t s1_d, s1_q;
  pfd_coord_t s2_d, s2_q;
  pfd_pos_t   pos_a, pos_b;

  assign s2_ready       = !s2_valid_q || loc_ready_i;
  assign s1_ready       = !s1_valid_q || s2_ready;
  assign cipher_i.ready = s1_ready;

  always_comb begin
    for (int r = 0; r < SqSize; r++) begin
      for (int c = 0; c < SqSize; c++) begin
        s1_d.m_a[r][c] = (key_i[r][c] == cipher_i.cipher_first);
        s1_d.m_b[r][c] = (key_i[r][c] == cipher_i.cipher_second);
      end
    end
  end

  always_comb begin
    pos_a       = first_hit(s1_q.m_a);
    pos_b       = first_hit(s1_q.m_b);
    s2_d.found  = pos_a.hit && pos_b.hit;
    s2_d.row_a  = pos_a.row;
    s2_d.col_a  = pos_a.col;
    s2_d.row_b  = pos_b.row;
    s2_d.col_b  = pos_b.col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= cipher_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // payload moves only with a word; hold otherwise
  always_ff @(posedge clk_i) begin
    if (s1_ready && cipher_i.valid) s1_q <= s1_d;
    if (s2_ready && s1_valid_q)     s2_q <= s2_d;
  end

  assign loc_valid_o = s2_valid_q;
  assign loc_o       = s2_q;

endmodule

// ===== src/pfd_pick.sv =====
// Stages 3-4: apply the row, column or rectangle rule to get target cells,
// then read them out of the key square. Depends on pfd_pkg and pfd_out_if.
`timescale 1ns / 1ps

module pfd_pick (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfd_pkg::key_sq_t    key_i,
  input  logic                loc_valid_i,
  output logic                loc_ready_o,
  input  pfd_pkg::pfd_coord_t loc_i,
  pfd_out_if.source           plain_o
);
  import pfd_pkg::*;

  logic       s3_valid_q, s4_valid_q;
  logic       s3_ready, s4_ready;
  pfd_coord_t s3_d, s3_q;
  char_t      pa_d, pb_d, pa_q, pb_q;
  logic       found_q;

  assign s4_ready    = !s4_valid_q || plain_o.ready;
  assign s3_ready    = !s3_valid_q || s4_ready;
  assign loc_ready_o = s3_ready;

  always_comb begin
    s3_d = loc_i;
    if (loc_i.row_a == loc_i.row_b) begin
      // same row: step left with wrap
      s3_d.col_a = dec_wrap(loc_i.col_a);
      s3_d.col_b = dec_wrap(loc_i.col_b);
    end else if (loc_i.col_a == loc_i.col_b) begin
      // same column: step up with wrap
      s3_d.row_a = dec_wrap(loc_i.row_a);
      s3_d.row_b = dec_wrap(loc_i.row_b);
    end else begin
      // rectangle: swap columns
      s3_d.col_a = loc_i.col_b;
      s3_d.col_b = loc_i.col_a;
    end
  end

  always_comb begin
    pa_d = key_i[s3_q.row_a][s3_q.col_a];
    pb_d = key_i[s3_q.row_b][s3_q.col_b];
    if (!s3_q.found) begin
      pa_d = '0;
      pb_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s3_ready) s3_valid_q <= loc_valid_i;
      if (s4_ready) s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && loc_valid_i) s3_q <= s3_d;
    if (s4_ready && s3_valid_q) begin
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      found_q <= s3_q.found;
    end
  end

  assign plain_o.valid        = s4_valid_q;
  assign plain_o.plain_first  = pa_q;
  assign plain_o.plain_second = pb_q;
  assign plain_o.found        = found_q;

endmodule

// ===== src/pfd_checker.sv =====
// Port-level checks for the Playfair digraph decoder, bound to the top.
// Depends on pfd_pkg and playfair_digraph_decoder.
`timescale 1ns / 1ps

module pfd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input pfd_pkg::char_t       plain_first_i,
  input pfd_pkg::char_t       plain_second_i,
  input logic                 found_i,
  input logic                 pready_i
);
  import pfd_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(plain_first_i)
      && $stable(plain_second_i) && $stable(found_i))
    else $error("result word changed while stalled");

  // a miss always reads out as zero characters
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> plain_first_i == '0 && plain_second_i == '0)
    else $error("miss with nonzero characters");

  // an empty output stage means no stage can be blocking the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with output stage empty");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready dropped");

endmodule

bind playfair_digraph_decoder pfd_checker u_pfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (cipher_i.ready),
  .out_valid_i    (plain_o.valid),
  .out_ready_i    (plain_o.ready),
  .plain_first_i  (plain_o.plain_first),
  .plain_second_i (plain_o.plain_second),
  .found_i        (plain_o.found),
  .pready_i       (pready)
);
